// ===== src/ppp_pkg.sv =====
// shared types, register indexes and the divider step of the point projector
`timescale 1ns / 1ps
package ppp_pkg;

   localparam int QUO_BITS = 33;

   typedef enum logic [2:0] {
      REG_FOV    = 3'd0,
      REG_NEAR   = 3'd1,
      REG_CAMZ   = 3'd2,
      REG_WIDTH  = 3'd3,
      REG_HEIGHT = 3'd4,
      REG_CAP    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [9:0]            idx;
      logic                  last;
      logic                  clamped;
      logic                  neg_x;
      logic                  neg_y;
      logic [31:0]           mag_x;
      logic [31:0]           mag_y;
      logic [31:0]           depth;
      logic [63:0]           prod_x;
      logic [63:0]           prod_y;
      logic                  big_x;
      logic                  big_y;
      logic [31:0]           rem_x;
      logic [31:0]           rem_y;
      logic [QUO_BITS-1:0]   quo_x;
      logic [QUO_BITS-1:0]   quo_y;
   } stage_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                            input logic [31:0] depth);
      logic [32:0] t;
      logic [32:0] d;
      begin
         t = {rem, nbit};
         d = t - {1'b0, depth};
         if (t >= {1'b0, depth}) begin
            div_step = {1'b1, d[31:0]};
         end else begin
            div_step = {1'b0, t[31:0]};
         end
      end
   endfunction

endpackage

// ===== src/perspective_point_projector.sv =====
// perspective point projector with near-plane clamp, pipelined top level
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   request | req_valid, req_stall, req_* fields | in
//   result  | rsp_valid, rsp_stall, rsp_* fields | out
//   csr     | csr_valid, csr_ready, index, data  | in
//
// one transaction per cycle sustained while the result is not stalled; the stages are
// entry, multiply, range check, 33 divider stages and the output register
// the latency is set by the 33-stage restoring divider, one quotient bit per stage
// the whole pipeline holds while the output register is full and stalled
// reset is synchronous; it clears valid bits and loads register defaults
// out-of-range indexes never enter the pipeline, so they yield no result
`timescale 1ns / 1ps
module perspective_point_projector
   import ppp_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [9:0]         req_point_index,
   input  logic signed [31:0] req_world_x,
   input  logic signed [31:0] req_world_y,
   input  logic signed [31:0] req_world_z,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_slot_index,
   output logic signed [31:0] rsp_proj_x,
   output logic signed [31:0] rsp_proj_y,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic               rsp_depth_clamped,
   output logic               rsp_overflowed,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int NST = 3 + QUO_BITS;

   // configuration registers
   logic [31:0] fov_ff;
   logic [30:0] near_ff;
   logic [31:0] camz_ff;
   logic [13:0] width_ff;
   logic [13:0] height_ff;
   logic [10:0] cap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff    <= 32'd98304000;
         near_ff   <= 31'd6554;
         camz_ff   <= 32'd0;
         width_ff  <= 14'd800;
         height_ff <= 14'd600;
         cap_ff    <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_FOV:    fov_ff    <= csr_data;
            REG_NEAR:   near_ff   <= csr_data[30:0];
            REG_CAMZ:   camz_ff   <= csr_data;
            REG_WIDTH:  width_ff  <= csr_data[13:0];
            REG_HEIGHT: height_ff <= csr_data[13:0];
            REG_CAP:    cap_ff    <= csr_data[10:0];
            default:    ;
         endcase
      end
   end

   // pipeline moves unless the output register holds a stalled result
   logic adv;
   logic out_vld_ff;
   assign adv       = !(out_vld_ff && rsp_stall);
   assign req_stall = !adv;

   // entry: bounds check, depth and near clamp, magnitudes
   logic              idx_ok;
   logic [30:0]       nearv;
   logic signed [32:0] depth_raw;
   logic              clamp;
   stage_type         entry;

   always_comb begin
      idx_ok    = ({7'd0, req_point_index} < {6'd0, cap_ff}) &&
                  ({7'd0, req_point_index} < 17'(MAX_POINTS));
      nearv     = (near_ff == 31'd0) ? 31'd1 : near_ff;
      depth_raw = {req_world_z[31], req_world_z} - {camz_ff[31], camz_ff};
      clamp     = depth_raw <= $signed({2'b00, nearv});
      entry          = '0;
      entry.idx      = req_point_index;
      entry.last     = req_last_point;
      entry.clamped  = clamp;
      entry.neg_x    = req_world_x[31];
      entry.neg_y    = req_world_y[31];
      entry.mag_x    = req_world_x[31] ? 32'(-req_world_x) : req_world_x;
      entry.mag_y    = req_world_y[31] ? 32'(-req_world_y) : req_world_y;
      entry.depth    = clamp ? {1'b0, nearv} : depth_raw[31:0];
   end

   stage_type st_ff [NST];
   stage_type st_in [NST];
   logic [NST-1:0] vld_ff;

   // multiply and range check stages
   always_comb begin
      st_in[0]        = entry;
      st_in[1]        = st_ff[0];
      st_in[1].prod_x = 64'(st_ff[0].mag_x) * 64'(fov_ff);
      st_in[1].prod_y = 64'(st_ff[0].mag_y) * 64'(fov_ff);
      // quotient at or above 2^33 saturates in any case
      st_in[2]        = st_ff[1];
      st_in[2].big_x  = {1'b0, st_ff[1].prod_x[63:33]} >= st_ff[1].depth;
      st_in[2].big_y  = {1'b0, st_ff[1].prod_y[63:33]} >= st_ff[1].depth;
      st_in[2].rem_x  = {1'b0, st_ff[1].prod_x[63:33]};
      st_in[2].rem_y  = {1'b0, st_ff[1].prod_y[63:33]};
      st_in[2].quo_x  = '0;
      st_in[2].quo_y  = '0;
   end

   // divider stages, highest quotient bit first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      localparam int B = QUO_BITS - 1 - k;
      logic [32:0] sx;
      logic [32:0] sy;
      always_comb begin
         sx = div_step(st_ff[2+k].rem_x, st_ff[2+k].prod_x[B], st_ff[2+k].depth);
         sy = div_step(st_ff[2+k].rem_y, st_ff[2+k].prod_y[B], st_ff[2+k].depth);
         st_in[3+k]          = st_ff[2+k];
         st_in[3+k].rem_x    = sx[31:0];
         st_in[3+k].rem_y    = sy[31:0];
         st_in[3+k].quo_x[B] = sx[32];
         st_in[3+k].quo_y[B] = sy[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid && idx_ok};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) st_ff[i] <= st_in[i];
      end
   end

   // final stage: sign, saturation, screen offset
   function automatic logic [32:0] sat_proj(input logic neg, input logic big,
                                            input logic [QUO_BITS-1:0] q);
      begin
         if (neg) begin
            if (big || q > 33'h0_8000_0000) sat_proj = {1'b1, 32'h8000_0000};
            else                            sat_proj = {1'b0, 32'(-q)};
         end else begin
            if (big || q > 33'h0_7FFF_FFFF) sat_proj = {1'b1, 32'h7FFF_FFFF};
            else                            sat_proj = {1'b0, q[31:0]};
         end
      end
   endfunction

   function automatic logic [32:0] sat_scr(input logic [31:0] p, input logic [39:0] half);
      logic signed [39:0] s;
      begin
         s = $signed({{8{p[31]}}, p}) + $signed(half);
         if (s > 40'sh00_7FFF_FFFF)       sat_scr = {1'b1, 32'h7FFF_FFFF};
         else if (s < -40'sh00_8000_0000) sat_scr = {1'b1, 32'h8000_0000};
         else                             sat_scr = {1'b0, s[31:0]};
      end
   endfunction

   logic [32:0] px_w, py_w, sx_w, sy_w;
   logic [39:0] half_w, half_h;
   stage_type   fin;

   always_comb begin
      fin    = st_ff[NST-1];
      half_w = 40'(width_ff) << (FRAC_BITS - 1);
      half_h = 40'(height_ff) << (FRAC_BITS - 1);
      px_w   = sat_proj(fin.neg_x, fin.big_x, fin.quo_x);
      py_w   = sat_proj(fin.neg_y, fin.big_y, fin.quo_y);
      sx_w   = sat_scr(px_w[31:0], half_w);
      sy_w   = sat_scr(py_w[31:0], half_h);
   end

   // output register
   logic [9:0]  idx_ff;
   logic [31:0] px_ff, py_ff, sx_ff, sy_ff;
   logic        clamp_ff, ovf_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff   <= fin.idx;
         px_ff    <= px_w[31:0];
         py_ff    <= py_w[31:0];
         sx_ff    <= sx_w[31:0];
         sy_ff    <= sy_w[31:0];
         clamp_ff <= fin.clamped;
         ovf_ff   <= px_w[32] | py_w[32] | sx_w[32] | sy_w[32];
         last_ff  <= fin.last;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_slot_index    = idx_ff;
   assign rsp_proj_x        = px_ff;
   assign rsp_proj_y        = py_ff;
   assign rsp_screen_x      = sx_ff;
   assign rsp_screen_y      = sy_ff;
   assign rsp_depth_clamped = clamp_ff;
   assign rsp_overflowed    = ovf_ff;
   assign rsp_last_out      = last_ff;

endmodule

// ===== src/ppp_checker.sv =====
// port-level checks of the point projector and their bind
`timescale 1ns / 1ps
module ppp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_proj_x,
   input logic        rsp_overflowed,
   input logic        csr_ready
);

   // request side holds exactly when a result waits stalled
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall)) else $error("stall link");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_proj_x) &&
      $stable(rsp_overflowed)) else $error("hold");

   // register port always takes writes
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");

endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_proj_x(rsp_proj_x), .rsp_overflowed(rsp_overflowed),
   .csr_ready(csr_ready)
);
